[src/pba_pkg.sv]
// Shared constants and types for the page bitmap allocator.
// No dependencies; imported by pba_ctrl and page_bitmap_allocator.
`default_nettype none

package pba_pkg;

   // Map geometry (power of two, up to 256 pages with IDX_W = 8)
   localparam int PAGES       = 256;
   localparam int PTR_W       = $clog2(PAGES);
   localparam int IDX_W       = 8;
   // Probe step is (STEP_MUL * p + STEP_ADD) mod PAGES
   localparam int STEP_MUL    = 13;
   localparam int STEP_ADD    = 5;
   localparam int STEP_W      = PTR_W + 4;
   localparam int PTR_RESET   = 32 % PAGES;

   // Request opcodes
   localparam logic OP_ALLOC  = 1'b0;
   localparam logic OP_FREE   = 1'b1;

   // Response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_RESPOND
   } state_type;

   // Usage map access from the controller
   typedef struct packed {
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic             wr_data;
   } mem_req_type;

   // Finished response handed to the output register
   typedef struct packed {
      logic             valid;
      logic             status;
      logic [IDX_W-1:0] page;
   } result_type;

endpackage

`default_nettype wire

[src/pba_ctrl.sv]
// Sequencer of the page bitmap allocator: clearing pass, probe walk and pointer.
// Depends on pba_pkg; drives the usage map held in page_bitmap_allocator.
`default_nettype none

module pba_ctrl
   import pba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_opcode,
   input  wire logic [IDX_W-1:0]   req_page_index,
   input  wire logic               slot_free,
   input  wire logic               rd_data,
   output      mem_req_type        mem,
   output      result_type         res
);

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  cnt_ff, cnt_in;
   logic              status_ff, status_in;
   logic [IDX_W-1:0]  page_ff, page_in;
   logic [STEP_W-1:0] step_sum;
   logic [PTR_W-1:0]  ptr_next;
   logic              req_fire;

   // Next probe position; modulo of a power of two is the low bits
   assign step_sum = STEP_W'(ptr_ff) * STEP_W'(STEP_MUL) + STEP_W'(STEP_ADD);
   assign ptr_next = step_sum[PTR_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Next state, memory access and result
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      page_in      = page_ff;
      mem.rd_en    = 1'b0;
      mem.rd_addr  = ptr_ff;
      mem.wr_en    = 1'b0;
      mem.wr_addr  = ptr_ff;
      mem.wr_data  = 1'b0;
      res.valid    = 1'b0;
      res.status   = status_ff;
      res.page     = page_ff;
      case (state_ff)
         ST_CLEAR: begin
            // one entry a cycle; page 0 starts out used
            mem.wr_en   = 1'b1;
            mem.wr_addr = cnt_ff;
            mem.wr_data = (cnt_ff == '0);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == PTR_W'(PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_FREE) begin
                  // pages beyond the map leave it unchanged
                  mem.wr_en   = (int'(req_page_index) < PAGES);
                  mem.wr_addr = PTR_W'(req_page_index);
                  mem.wr_data = 1'b0;
                  status_in   = STATUS_OK;
                  page_in     = '0;
                  state_in    = ST_RESPOND;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = ptr_ff;
                  cnt_in      = '0;
                  state_in    = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            // read data belongs to the page at ptr_ff
            if (!rd_data) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = ptr_ff;
               mem.wr_data = 1'b1;
               status_in   = STATUS_OK;
               page_in     = IDX_W'(ptr_ff);
               state_in    = ST_RESPOND;
            end else begin
               ptr_in = ptr_next;
               if (cnt_ff == PTR_W'(PAGES - 1)) begin
                  status_in = STATUS_FULL;
                  page_in   = '0;
                  state_in  = ST_RESPOND;
               end else begin
                  cnt_in      = cnt_ff + 1'b1;
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = ptr_next;
               end
            end
         end
         ST_RESPOND: begin
            if (slot_free) begin
               res.valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff   <= PTR_W'(PTR_RESET);
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      page_ff   <= page_in;
   end

endmodule

`default_nettype wire

[src/page_bitmap_allocator.sv]
// Top level of the page bitmap allocator: usage map memory and response register.
// Depends on pba_pkg and pba_ctrl.
//
// Usage:
//   Request channel (req_valid/req_ready): req_opcode allocates a page or frees
//   req_page_index. Response channel (rsp_valid/rsp_ready): rsp_status and
//   rsp_page_granted, exactly one response per request, in order.
//   One request is worked on at a time. A free goes from acceptance through
//   ST_RESPOND to the response register. An allocate reads one usage bit per
//   cycle along the probe walk through the usage map, from 1 up to 256 probes.
//   After reset a clearing pass writes all 256 map entries, one per cycle;
//   req_ready stays low until the pass ends. Page 0 then reads as used and
//   the probe pointer is 32.
//   The response sits in an output register. A new request is accepted while
//   it waits; a finished request is held until the register frees, so a
//   stalled receiver holds off at most one further request.
`default_nettype none

module page_bitmap_allocator
   import pba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic             req_opcode,
   input  wire logic [IDX_W-1:0] req_page_index,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      logic             rsp_status,
   output      logic [IDX_W-1:0] rsp_page_granted
);

   logic             usage_mem [PAGES];
   logic             rd_data_ff;
   mem_req_type      mem;
   result_type       res;
   logic             slot_free;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff;
   logic [IDX_W-1:0] rsp_page_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   pba_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_page_index (req_page_index),
      .slot_free      (slot_free),
      .rd_data        (rd_data_ff),
      .mem            (mem),
      .res            (res)
   );

   // Usage map: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         usage_mem[mem.wr_addr] <= mem.wr_data;
      end
      if (mem.rd_en) begin
         rd_data_ff <= usage_mem[mem.rd_addr];
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_status_ff <= res.status;
         rsp_page_ff   <= res.page;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_granted = rsp_page_ff;

endmodule

`default_nettype wire

[dv/tb_page_bitmap_allocator.sv]
// Self-checking testbench for page_bitmap_allocator: a shadow usage map predicts
// each response, which is compared field by field. Depends on pba_pkg and the RTL.
`timescale 1ns / 1ps

module tb_page_bitmap_allocator
   import pba_pkg::*;
();

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] page;
   } grant_type;

   // Cycles to wait after the last response before closing the run
   localparam int SETTLE_CYCLES = 2 * PAGES + 16;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_opcode = OP_ALLOC;
   logic [IDX_W-1:0] req_page_index = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_status;
   logic [IDX_W-1:0] rsp_page_granted;

   // Shadow copy of the allocator state
   logic [PAGES-1:0] shadow_used;
   logic [PTR_W-1:0] shadow_probe;

   grant_type pending_grants[$];
   int        error_count = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;

   page_bitmap_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_page_index   (req_page_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_granted (rsp_page_granted)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Work out the response to one request and update the shadow map
   function automatic void predict_grant(input logic op, input logic [IDX_W-1:0] idx,
                                         output grant_type g);
      int tries;
      g.status = STATUS_OK;
      g.page   = '0;
      if (op == OP_FREE) begin
         if (int'(idx) < PAGES) shadow_used[idx] = 1'b0;
         return;
      end
      // probe walk, at most one test per page
      for (tries = 0; tries < PAGES; tries++) begin
         if (!shadow_used[shadow_probe]) begin
            shadow_used[shadow_probe] = 1'b1;
            g.page = IDX_W'(shadow_probe);
            return;
         end
         shadow_probe = PTR_W'((STEP_MUL * int'(shadow_probe) + STEP_ADD) % PAGES);
      end
      g.status = STATUS_FULL;
   endfunction

   // Random page currently marked used, or any page if none is
   function automatic logic [IDX_W-1:0] pick_used_page();
      int start;
      int p;
      start = $urandom_range(PAGES - 1);
      for (int i = 0; i < PAGES; i++) begin
         p = (start + i) % PAGES;
         if (shadow_used[p]) return IDX_W'(p);
      end
      return IDX_W'(start);
   endfunction

   // Response checker: a response seen here is taken at the next rising edge
   always @(negedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $error("response with nothing outstanding: status %0d page %0d",
                   rsp_status, rsp_page_granted);
            error_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_page_granted !== want.page) begin
               $error("page_granted: expected %0d, got %0d", want.page, rsp_page_granted);
               error_count++;
            end
         end
      end
   end

   // Send one request; returns at the edge where it is taken
   task automatic issue_request(input logic op, input logic [IDX_W-1:0] idx);
      grant_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_page_index <= idx;
      do @(negedge clock); while (!req_ready);
      predict_grant(op, idx, want);
      pending_grants.push_back(want);
      @(posedge clock);
   endtask

   // Stop sending until every outstanding response has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      issue_request(OP_ALLOC, 8'h00);          // first grant comes from the reset pointer
      issue_request(OP_ALLOC, 8'hFF);          // index ignored on allocate
      issue_request(OP_FREE, 8'd32);
      issue_request(OP_FREE, 8'd32);           // already free
      issue_request(OP_FREE, 8'h00);           // page 0, reserved at reset
      issue_request(OP_FREE, 8'hFF);
      issue_request(OP_FREE, 8'hAA);
      issue_request(OP_FREE, 8'h55);
      issue_request(OP_ALLOC, 8'hAA);
      issue_request(OP_ALLOC, 8'h55);
      issue_request(OP_ALLOC, 8'h00);
      issue_request(OP_FREE, pick_used_page());
      issue_request(OP_ALLOC, 8'h00);
      issue_request(OP_ALLOC, 8'h00);          // page 0 is free now, walk may reach it
   endtask

   // Fill the whole map, then hit the no-space path and recover
   task automatic test_exhaust_map();
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      while (~&shadow_used) issue_request(OP_ALLOC, IDX_W'($urandom));
      issue_request(OP_ALLOC, 8'h00);
      issue_request(OP_ALLOC, 8'hFF);
      issue_request(OP_FREE, pick_used_page());
      issue_request(OP_ALLOC, 8'h00);
      issue_request(OP_ALLOC, 8'h00);
      issue_request(OP_FREE, 8'h00);
      issue_request(OP_ALLOC, 8'h00);
      hold_until_drained();
   endtask

   // Mixed allocate/free traffic; most frees release a page that is in use
   task automatic test_random_traffic(input int count, input int alloc_pct,
                                      input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) hold_until_drained();
         if ($urandom_range(99) < alloc_pct)
            issue_request(OP_ALLOC, IDX_W'($urandom));
         else if ($urandom_range(99) < 70)
            issue_request(OP_FREE, pick_used_page());
         else
            issue_request(OP_FREE, IDX_W'($urandom));
      end
      hold_until_drained();
   endtask

   initial begin
      shadow_used    = '0;
      shadow_used[0] = 1'b1;
      shadow_probe   = PTR_W'(PTR_RESET);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_exhaust_map();
      test_random_traffic(280, 70, 0, 0);
      test_random_traffic(280, 95, 64, 0);
      test_random_traffic(280, 35, 0, 64);
      test_random_traffic(280, 90, 23, 23);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
